@@ hw/rtl/rio_pkg.sv @@
// ----------------------------------------------------------------------------
// rio_pkg
// Shared types and constants for the RAM and I/O port expander pin unit.
// ----------------------------------------------------------------------------
package rio_pkg;

    localparam logic [2:0] PIN_ALE   = 3'd0;
    localparam logic [2:0] PIN_RD    = 3'd1;
    localparam logic [2:0] PIN_WR    = 3'd2;
    localparam logic [2:0] PIN_CE    = 3'd3;
    localparam logic [2:0] PIN_IO    = 3'd4;
    localparam logic [2:0] PIN_RESET = 3'd5;

    localparam logic [1:0] SEL_CMD    = 2'd0;
    localparam logic [1:0] SEL_PORT_A = 2'd1;
    localparam logic [1:0] SEL_PORT_B = 2'd2;
    localparam logic [1:0] SEL_PORT_C = 2'd3;

    localparam logic [1:0] PORT_A = 2'd0;
    localparam logic [1:0] PORT_B = 2'd1;
    localparam logic [1:0] PORT_C = 2'd2;

    localparam logic [1:0] MODE_ALT1 = 2'd0;
    localparam logic [1:0] MODE_ALT2 = 2'd1;
    localparam logic [1:0] MODE_ALT3 = 2'd2;
    localparam logic [1:0] MODE_ALT4 = 2'd3;

    typedef struct packed {
        logic [2:0] req_type;
        logic       pin_level;
        logic [7:0] bus_data;
    } t_req;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_data;
        logic       port_write;
        logic [1:0] port_which;
        logic [7:0] port_a_value;
        logic [7:0] port_b_value;
        logic [7:0] port_c_value;
        logic       port_a_is_output;
        logic       port_b_is_output;
        logic [1:0] port_c_mode;
        logic       port_a_irq_enable;
        logic       port_b_irq_enable;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    // command bits 3:2 to port c mode
    function automatic logic [1:0] f_mode_map(input logic [1:0] code);
        logic [1:0] mode;
        unique case (code)
            2'd0:    mode = MODE_ALT1;
            2'd1:    mode = MODE_ALT3;
            2'd2:    mode = MODE_ALT4;
            default: mode = MODE_ALT2;
        endcase
        return mode;
    endfunction

endpackage

@@ hw/rtl/rio_ctrl.sv @@
// ----------------------------------------------------------------------------
// rio_ctrl
// Sequencer: takes a pin event, runs it through the datapath, strobes result.
// ----------------------------------------------------------------------------
module rio_ctrl
    import rio_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_EXEC;
            S_EXEC: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = (r_state == S_RESP);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_cmd.exec)
        else $error("accepted transfer not executed");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (o_done && busy))
        else $error("execution not followed by result strobe");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("controller did not return to idle");

endmodule

@@ hw/rtl/rio_dp.sv @@
// ----------------------------------------------------------------------------
// rio_dp
// Datapath: pin levels, address latch, port and mode registers, data RAM.
// ----------------------------------------------------------------------------
module rio_dp
    import rio_pkg::*;
#(
    parameter int RAM_DEPTH = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_req    i_req,
    output t_rsp    o_rsp
);

    localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // address to ram index, worked out at elaboration
    logic [AW-1:0] idx_tbl [256];

    for (genvar g = 0; g < 256; g++) begin : g_idx
        assign idx_tbl[g] = AW'(g % RAM_DEPTH);
    end

    t_req          r_req;
    logic [7:0]    r_addr;
    logic          r_ale, r_rd, r_wr, r_ce, r_io;
    logic [7:0]    r_port_a, r_port_b, r_port_c;
    logic [1:0]    r_dir, r_mode, r_irq;
    logic          r_rvalid, r_from_ram, r_hit, r_pwrite;
    logic [1:0]    r_pwhich;
    logic [7:0]    r_io_data, r_mem_q;
    logic [RAM_DEPTH-1:0] r_valid;
    logic [7:0]    mem [RAM_DEPTH];

    logic          n_ale, n_rd, n_wr, n_ce, n_io;
    logic [7:0]    n_port_a, n_port_b, n_port_c;
    logic [1:0]    n_dir, n_mode, n_irq;
    logic          n_rvalid, n_from_ram, n_pwrite;
    logic [1:0]    n_pwhich;
    logic [7:0]    n_io_data;
    logic          rd_act, wr_act, ram_we, clr_all;
    logic [1:0]    sel;
    logic [AW-1:0] idx;

    function automatic logic i_req_type_is(input logic [2:0] code);
        return r_req.req_type == code;
    endfunction

    assign sel    = r_addr[1:0];
    assign idx    = idx_tbl[r_addr];
    assign rd_act = (i_req_type_is(PIN_RD)) && !r_rd && r_req.pin_level && !r_ce;
    assign wr_act = (i_req_type_is(PIN_WR)) && !r_wr && r_req.pin_level && !r_ce;
    assign ram_we = i_cmd.exec && wr_act && !r_io;
    assign clr_all = i_cmd.exec && i_req_type_is(PIN_RESET) && r_req.pin_level;

    always_comb begin
        n_ale      = r_ale;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_ce       = r_ce;
        n_io       = r_io;
        n_port_a   = r_port_a;
        n_port_b   = r_port_b;
        n_port_c   = r_port_c;
        n_dir      = r_dir;
        n_mode     = r_mode;
        n_irq      = r_irq;
        n_rvalid   = 1'b0;
        n_from_ram = 1'b0;
        n_pwrite   = 1'b0;
        n_pwhich   = PORT_A;
        n_io_data  = 8'd0;
        unique case (r_req.req_type)
            PIN_ALE: n_ale = r_req.pin_level;
            PIN_RD: begin
                n_rd = r_req.pin_level;
                if (rd_act) begin
                    n_rvalid   = 1'b1;
                    n_from_ram = !r_io;
                    unique case (sel)
                        SEL_PORT_A: n_io_data = r_port_a;
                        SEL_PORT_B: n_io_data = r_port_b;
                        SEL_PORT_C: n_io_data = r_port_c;
                        default:    n_io_data = 8'd0;
                    endcase
                end
            end
            PIN_WR: begin
                n_wr = r_req.pin_level;
                if (wr_act && r_io) begin
                    unique case (sel)
                        SEL_PORT_A: begin
                            n_port_a = r_req.bus_data;
                            n_pwrite = 1'b1;
                            n_pwhich = PORT_A;
                        end
                        SEL_PORT_B: begin
                            n_port_b = r_req.bus_data;
                            n_pwrite = 1'b1;
                            n_pwhich = PORT_B;
                        end
                        SEL_PORT_C: begin
                            n_port_c = r_req.bus_data;
                            n_pwrite = 1'b1;
                            n_pwhich = PORT_C;
                        end
                        default: begin
                            n_dir  = r_req.bus_data[1:0];
                            n_mode = f_mode_map(r_req.bus_data[3:2]);
                            n_irq  = r_req.bus_data[5:4];
                        end
                    endcase
                end
            end
            PIN_CE: n_ce = r_req.pin_level;
            PIN_IO: n_io = r_req.pin_level;
            PIN_RESET: begin
                if (r_req.pin_level) begin
                    n_port_a = 8'd0;
                    n_port_b = 8'd0;
                    n_port_c = 8'd0;
                    n_dir    = 2'd0;
                    n_mode   = MODE_ALT1;
                    n_irq    = 2'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            if (i_req_type_is(PIN_ALE) && r_ale && !r_req.pin_level) begin
                r_addr <= r_req.bus_data;
            end
            r_rvalid   <= n_rvalid;
            r_from_ram <= n_from_ram;
            r_pwrite   <= n_pwrite;
            r_pwhich   <= n_pwhich;
            r_io_data  <= n_io_data;
            r_hit      <= r_valid[idx];
            r_mem_q    <= mem[idx];
        end
        if (ram_we) begin
            mem[idx] <= r_req.bus_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ale    <= 1'b0;
            r_rd     <= 1'b0;
            r_wr     <= 1'b0;
            r_ce     <= 1'b0;
            r_io     <= 1'b0;
            r_port_a <= 8'd0;
            r_port_b <= 8'd0;
            r_port_c <= 8'd0;
            r_dir    <= 2'd0;
            r_mode   <= MODE_ALT1;
            r_irq    <= 2'd0;
            r_valid  <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_ale    <= n_ale;
                r_rd     <= n_rd;
                r_wr     <= n_wr;
                r_ce     <= n_ce;
                r_io     <= n_io;
                r_port_a <= n_port_a;
                r_port_b <= n_port_b;
                r_port_c <= n_port_c;
                r_dir    <= n_dir;
                r_mode   <= n_mode;
                r_irq    <= n_irq;
            end
            if (clr_all) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[idx] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_rsp.read_valid        = r_rvalid;
        o_rsp.read_data         = r_from_ram ? (r_hit ? r_mem_q : 8'd0) : r_io_data;
        o_rsp.port_write        = r_pwrite;
        o_rsp.port_which        = r_pwhich;
        o_rsp.port_a_value      = r_port_a;
        o_rsp.port_b_value      = r_port_b;
        o_rsp.port_c_value      = r_port_c;
        o_rsp.port_a_is_output  = r_dir[0];
        o_rsp.port_b_is_output  = r_dir[1];
        o_rsp.port_c_mode       = r_mode;
        o_rsp.port_a_irq_enable = r_irq[0];
        o_rsp.port_b_irq_enable = r_irq[1];
    end

endmodule

@@ hw/rtl/ram_io_port_expander_pins_unit.sv @@
// ----------------------------------------------------------------------------
// ram_io_port_expander_pins_unit
// Pin-event model of a multiplexed-bus RAM and I/O port expander.
// ----------------------------------------------------------------------------
// sequencing: the event is registered on load, applied in the execute step and
//   strobed in the result step; a new event is taken only when idle, as the load,
//   execute and result steps of the sequencer run around the single RAM port
// reset: synchronous, clears pin levels, ports, modes and RAM valid bits at once
// the result is shown for one cycle on o_done; the receiver cannot stall
module ram_io_port_expander_pins_unit
    import rio_pkg::*;
#(
    parameter int RAM_DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    t_dp_cmd cmd;

    rio_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    rio_dp #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
